FILE: rtl/core/dbrq_pkg.sv
// ----------------------------------------------------------------------------
// dbrq_pkg: shared types and constants of the region query block
// Field widths, derived datapath widths, register indexes and the control
// word that travels beside the lane pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dbrq_pkg;

  // Block sizing
  localparam int MaxDims       = 4;
  localparam int MaxNeighbours = 65536;
  localparam int CoordBits     = 24;

  // Field widths
  localparam int CoordW   = 24;
  localparam int IdxW     = 30;
  localparam int LabelInW = 32;
  localparam int LabelW   = 31;
  localparam int CountW   = 17;
  localparam int EpsW     = 52;
  localparam int OffsW    = 30;
  localparam int DimsW    = 3;
  localparam int CfgIdxW  = 2;

  // Datapath widths: |diff| <= 2^CoordW, square <= 2^(2*CoordW)
  localparam int DiffW = CoordW + 1;
  localparam int SqW   = 2 * CoordW + 1;
  localparam int SumW  = SqW + 2;

  // Stream data widths, padded to whole bytes
  localparam int InDataRaw  = IdxW + 4 * CoordW + LabelInW;
  localparam int InDataW    = ((InDataRaw + 7) / 8) * 8;
  localparam int OutDataRaw = IdxW + 1 + CountW + LabelW;
  localparam int OutDataW   = ((OutDataRaw + 7) / 8) * 8;

  // Count saturates at the neighbour limit or the counter's top value
  localparam int CountLimitInt = (MaxNeighbours > 131071) ? 131071 : MaxNeighbours;
  localparam logic [CountW-1:0] CountLimit = CountW'(CountLimitInt);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgEps    = 2'd0,
    CfgOffset = 2'd1,
    CfgDims   = 2'd2
  } cfg_reg_e;

  // Input item kind carried in tuser
  typedef enum logic {
    OpStart     = 1'b0,
    OpCandidate = 1'b1
  } op_e;

  // Per-item control word riding beside the lanes
  typedef struct packed {
    logic              cand;
    logic [IdxW-1:0]   idx;
    logic              label_neg;
    logic [LabelW-1:0] label_mag;
    logic [LabelW-1:0] init_label;
    logic              last;
  } dbrq_ctl_t;

  // One result transaction
  typedef struct packed {
    logic              last;
    logic [LabelW-1:0] label;
    logic [CountW-1:0] count;
    logic              in_eps;
    logic [IdxW-1:0]   idx;
  } dbrq_res_t;

  // Take the low CoordBits bits and sign-extend one bit past the field
  function automatic logic signed [DiffW-1:0] sext_coord(input logic [CoordW-1:0] v);
    sext_coord = {{(DiffW - CoordBits){v[CoordBits-1]}}, v[CoordBits-1:0]};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dbscan_region_query_top.sv
// ----------------------------------------------------------------------------
// dbscan_region_query_top: epsilon-neighborhood query engine
// Streams candidates against one query point and reports each one's match result.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle unless the output stalls, start and
// candidate alike, with no gaps between queries. On its way to the output
// register a candidate has its per-dimension difference registered at its
// accepting edge, then the per-dimension square, the lane sum, and the radius
// compare with the count and label update are registered in turn. Start
// transactions produce no result. Downstream stalls hold the whole pipeline;
// tready follows the output register (free or being taken the same cycle).
// Configuration writes are always accepted and must only happen while the
// pipeline is empty.
`default_nettype none

module dbscan_region_query_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write channel
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [dbrq_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [dbrq_pkg::EpsW-1:0]       cfg_data_i,
  // Input stream
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // pt_idx[29:0], coord_0[53:30], coord_1[77:54], coord_2[101:78],
  // coord_3[125:102], neighbour_label[157:126], zero pad[159:158]
  input  wire logic [dbrq_pkg::InDataW-1:0]    s_axis_tdata,
  // operation[0]
  input  wire logic                            s_axis_tuser,
  input  wire logic                            s_axis_tlast,
  // Output stream
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // neighbour_index[29:0], within_eps[30], match_count[47:31],
  // run_label[78:48], zero pad[79]
  output      logic [dbrq_pkg::OutDataW-1:0]   m_axis_tdata,
  output      logic                            m_axis_tlast
);

  localparam int LabLo = dbrq_pkg::IdxW + dbrq_pkg::MaxDims * dbrq_pkg::CoordW;

  logic                                              adv, accept, load;
  logic [dbrq_pkg::EpsW-1:0]                         eps;
  logic [dbrq_pkg::OffsW-1:0]                        offset;
  logic [dbrq_pkg::DimsW-1:0]                        dims;
  logic [dbrq_pkg::IdxW-1:0]                         in_idx;
  logic [dbrq_pkg::LabelInW-1:0]                     in_label;
  logic [dbrq_pkg::LabelInW-1:0]                     neg_label;
  dbrq_pkg::dbrq_ctl_t                               ctl_d, ctl1_q, ctl2_q;
  logic                                              v1_q, v2_q;
  logic [dbrq_pkg::MaxDims-1:0][dbrq_pkg::SqW-1:0]   sq;
  logic                                              out_valid;
  dbrq_pkg::dbrq_res_t                               res;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  dbrq_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (cfg_valid_i),
    .index_i  (cfg_index_i),
    .data_i   (cfg_data_i),
    .eps_o    (eps),
    .offset_o (offset),
    .dims_o   (dims)
  );

  // Handshake: the pipeline moves when the result register can take data
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;
  assign load          = accept && (dbrq_pkg::op_e'(s_axis_tuser) == dbrq_pkg::OpStart);

  // Control word for the transaction
  assign in_idx    = s_axis_tdata[dbrq_pkg::IdxW-1:0];
  assign in_label  = s_axis_tdata[LabLo +: dbrq_pkg::LabelInW];
  assign neg_label = ~in_label + dbrq_pkg::LabelInW'(1);

  always_comb begin
    ctl_d.cand       = (dbrq_pkg::op_e'(s_axis_tuser) == dbrq_pkg::OpCandidate);
    ctl_d.idx        = in_idx;
    ctl_d.label_neg  = in_label[dbrq_pkg::LabelInW-1];
    ctl_d.label_mag  = neg_label[dbrq_pkg::LabelInW-1] ? '1
                                                       : neg_label[dbrq_pkg::LabelW-1:0];
    ctl_d.init_label = dbrq_pkg::LabelW'({1'b0, offset}) + dbrq_pkg::LabelW'(in_idx)
                       + dbrq_pkg::LabelW'(1);
    ctl_d.last       = s_axis_tlast;
  end

  // Control pipeline alongside the lane stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl1_q <= ctl_d;
      ctl2_q <= ctl1_q;
    end
  end

  // Per-dimension lanes
  for (genvar d = 0; d < dbrq_pkg::MaxDims; d++) begin : g_lane
    dbrq_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .load_i  (load),
      .use_i   (dims > dbrq_pkg::DimsW'(d)),
      .coord_i (s_axis_tdata[dbrq_pkg::IdxW + d*dbrq_pkg::CoordW +: dbrq_pkg::CoordW]),
      .sq_o    (sq[d])
    );
  end

  // Merge, compare and result register
  dbrq_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (v2_q),
    .ctl_i       (ctl2_q),
    .sq_i        (sq),
    .eps_i       (eps),
    .out_valid_o (out_valid),
    .res_o       (res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = res.last;
  assign m_axis_tdata  = dbrq_pkg::OutDataW'({res.label, res.count, res.in_eps, res.idx});

endmodule

`default_nettype wire

FILE: rtl/core/dbrq_lane.sv
// ----------------------------------------------------------------------------
// dbrq_lane: one coordinate dimension of the distance datapath
// Holds the query coordinate, forms |q - c| and then its square in two
// registered steps. Lanes outside the active dimension count give zero.
// ----------------------------------------------------------------------------
`default_nettype none

module dbrq_lane (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         adv_i,
  input  wire logic                         load_i,
  input  wire logic                         use_i,
  input  wire logic [dbrq_pkg::CoordW-1:0]  coord_i,
  output      logic [dbrq_pkg::SqW-1:0]     sq_o
);

  logic [dbrq_pkg::CoordW-1:0]        qcoord_q;
  logic signed [dbrq_pkg::DiffW-1:0]  diff;
  logic [dbrq_pkg::DiffW-1:0]         absd_d, absd_q;
  logic [2*dbrq_pkg::DiffW-1:0]       prod;
  logic [dbrq_pkg::SqW-1:0]           sq_q;

  // Query coordinate, loaded by a start transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qcoord_q <= '0;
    end else if (load_i) begin
      qcoord_q <= dbrq_pkg::CoordW'(dbrq_pkg::sext_coord(coord_i));
    end
  end

  // Absolute difference
  always_comb begin
    diff   = dbrq_pkg::sext_coord(qcoord_q) - dbrq_pkg::sext_coord(coord_i);
    absd_d = diff[dbrq_pkg::DiffW-1] ? dbrq_pkg::DiffW'(-diff) : dbrq_pkg::DiffW'(diff);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      absd_q <= absd_d;
    end
  end

  // Square, masked for unused dimensions
  assign prod = absd_q * absd_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sq_q <= use_i ? prod[dbrq_pkg::SqW-1:0] : '0;
    end
  end

  assign sq_o = sq_q;

endmodule

`default_nettype wire

FILE: rtl/core/dbrq_merge.sv
// ----------------------------------------------------------------------------
// dbrq_merge: lane merge, threshold compare and running accumulators
// Sums the lane squares, compares with the squared radius, keeps the
// match count and the running label, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dbrq_merge (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          adv_i,
  input  wire logic                                          valid_i,
  input  wire dbrq_pkg::dbrq_ctl_t                           ctl_i,
  input  wire logic [dbrq_pkg::MaxDims-1:0][dbrq_pkg::SqW-1:0] sq_i,
  input  wire logic [dbrq_pkg::EpsW-1:0]                     eps_i,
  output      logic                                          out_valid_o,
  output      dbrq_pkg::dbrq_res_t                           res_o
);

  logic                           v3_q;
  dbrq_pkg::dbrq_ctl_t            ctl3_q;
  logic [dbrq_pkg::SumW-1:0]      sum_d, sum_q;
  logic                           step, hit;
  logic [dbrq_pkg::CountW-1:0]    count_d, count_q;
  logic [dbrq_pkg::LabelW-1:0]    label_d, label_q;
  logic                           out_valid_d, out_valid_q;
  dbrq_pkg::dbrq_res_t            res_d, res_q;

  // Sum of lane squares
  always_comb begin
    sum_d = '0;
    for (int d = 0; d < dbrq_pkg::MaxDims; d++) begin
      sum_d = sum_d + dbrq_pkg::SumW'(sq_i[d]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sum_q  <= sum_d;
      ctl3_q <= ctl_i;
    end
  end

  // Compare and accumulator update
  assign step = adv_i && v3_q;
  assign hit  = ({{(dbrq_pkg::EpsW - dbrq_pkg::SumW){1'b0}}, sum_q} <= eps_i);

  always_comb begin
    count_d = count_q;
    label_d = label_q;
    if (!ctl3_q.cand) begin
      count_d = '0;
      label_d = ctl3_q.init_label;
    end else if (hit) begin
      if (count_q < dbrq_pkg::CountLimit) begin
        count_d = count_q + dbrq_pkg::CountW'(1);
      end
      if (ctl3_q.label_neg && (ctl3_q.label_mag < label_q)) begin
        label_d = ctl3_q.label_mag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      label_q <= '0;
    end else if (step) begin
      count_q <= count_d;
      label_q <= label_d;
    end
  end

  // Result register
  always_comb begin
    out_valid_d  = out_valid_q;
    if (adv_i) begin
      out_valid_d = v3_q && ctl3_q.cand;
    end
    res_d.idx    = ctl3_q.idx;
    res_d.in_eps = hit;
    res_d.count  = count_d;
    res_d.label  = label_d;
    res_d.last   = ctl3_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && ctl3_q.cand) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // Checks
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dbrq_pkg::CountLimit)
    else $error("match count above limit");

  a_miss_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && ctl3_q.cand && !hit) |=> (count_q == $past(count_q)))
    else $error("count changed on a miss");

  a_pos_label_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && ctl3_q.cand && !ctl3_q.label_neg) |=> (label_q == $past(label_q)))
    else $error("label changed by a non-negative neighbour label");

  a_cand_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && ctl3_q.cand) |=> out_valid_q)
    else $error("candidate produced no result");

endmodule

`default_nettype wire

FILE: rtl/core/dbrq_lane_dummy_unused.sv
// ----------------------------------------------------------------------------
// dbrq_cfg: configuration register file
// Holds the squared radius, label offset and active dimension count.
// ----------------------------------------------------------------------------
`default_nettype none

module dbrq_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           we_i,
  input  wire logic [dbrq_pkg::CfgIdxW-1:0]   index_i,
  input  wire logic [dbrq_pkg::EpsW-1:0]      data_i,
  output      logic [dbrq_pkg::EpsW-1:0]      eps_o,
  output      logic [dbrq_pkg::OffsW-1:0]     offset_o,
  output      logic [dbrq_pkg::DimsW-1:0]     dims_o
);

  logic [dbrq_pkg::EpsW-1:0]  eps_q;
  logic [dbrq_pkg::OffsW-1:0] offset_q;
  logic [dbrq_pkg::DimsW-1:0] dims_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q    <= '0;
      offset_q <= '0;
      dims_q   <= dbrq_pkg::DimsW'(3);
    end else if (we_i) begin
      case (dbrq_pkg::cfg_reg_e'(index_i))
        dbrq_pkg::CfgEps:    eps_q    <= data_i;
        dbrq_pkg::CfgOffset: offset_q <= data_i[dbrq_pkg::OffsW-1:0];
        dbrq_pkg::CfgDims:   dims_q   <= data_i[dbrq_pkg::DimsW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign eps_o    = eps_q;
  assign offset_o = offset_q;
  assign dims_o   = dims_q;

endmodule

`default_nettype wire

FILE: dv/dbscan_region_query_top_tb.sv
// ----------------------------------------------------------------------------
// dbscan_region_query_top_tb: self-checking bench for the region query engine
// Drives start and candidate transactions with random gaps and downstream
// stalls. A scoreboard tracks the query point, match count and running label,
// and compares every result field against its own prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module dbscan_region_query_top_tb;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int LongHold      = 300;
  localparam int DrainPause    = 8;
  localparam int NumPhases     = 6;
  localparam int PhaseItems    = 290;

  localparam logic [dbrq_pkg::CoordW-1:0] CMin = 24'h800000;
  localparam logic [dbrq_pkg::CoordW-1:0] CMax = 24'h7FFFFF;

  // One input transaction, fields as the block sees them
  typedef struct packed {
    dbrq_pkg::op_e                    op;
    logic [dbrq_pkg::IdxW-1:0]        idx;
    logic [3:0][dbrq_pkg::CoordW-1:0] coord;
    logic [dbrq_pkg::LabelInW-1:0]    label;
    logic                             last;
  } rq_item_t;

  // One expected output transaction
  typedef struct packed {
    logic                          last;
    logic [dbrq_pkg::OutDataW-1:0] data;
  } rq_result_t;

  // Tracks query state and holds the expected result of every candidate
  class region_match_scoreboard;
    logic [dbrq_pkg::EpsW-1:0]        eps_sq;
    logic [dbrq_pkg::OffsW-1:0]       offset;
    logic [dbrq_pkg::DimsW-1:0]       dims;
    logic [3:0][dbrq_pkg::CoordW-1:0] query_pt;
    logic [dbrq_pkg::CountW-1:0]      match_cnt;
    logic [dbrq_pkg::LabelW-1:0]      min_label;
    rq_result_t                       pending_matches[$];
    int                               errors;

    function new();
      eps_sq    = '0;
      offset    = '0;
      dims      = 3'd3;
      query_pt  = '0;
      match_cnt = '0;
      min_label = '0;
      errors    = 0;
    endfunction

    function void set_reg(dbrq_pkg::cfg_reg_e r, logic [dbrq_pkg::EpsW-1:0] v);
      case (r)
        dbrq_pkg::CfgEps:    eps_sq = v;
        dbrq_pkg::CfgOffset: offset = v[dbrq_pkg::OffsW-1:0];
        dbrq_pkg::CfgDims:   dims   = v[dbrq_pkg::DimsW-1:0];
        default: ;
      endcase
    endfunction

    // Accepted input: update query state, queue the result a candidate gives
    function void take_item(rq_item_t it);
      longint            diff;
      longint unsigned   sq_dist;
      int                n;
      logic              hit;
      logic [32:0]       mag;
      if (it.op == dbrq_pkg::OpStart) begin
        query_pt  = it.coord;
        match_cnt = '0;
        min_label = {1'b0, offset} + {1'b0, it.idx} + 31'd1;
        return;
      end
      n = (dims > dbrq_pkg::MaxDims) ? dbrq_pkg::MaxDims : int'(dims);
      sq_dist = 0;
      for (int d = 0; d < n; d++) begin
        diff = longint'($signed(query_pt[d])) - longint'($signed(it.coord[d]));
        if (diff < 0) diff = -diff;
        sq_dist += longint'(diff * diff);
      end
      hit = (sq_dist <= 64'(eps_sq));
      if (hit) begin
        if (match_cnt < dbrq_pkg::CountLimit)
          match_cnt = match_cnt + dbrq_pkg::CountW'(1);
        // core label: take magnitude, clamp the most negative value
        if (it.label[dbrq_pkg::LabelInW-1]) begin
          mag = 33'h1_0000_0000 - {1'b0, it.label};
          if (mag > 33'h0_7FFF_FFFF) mag = 33'h0_7FFF_FFFF;
          if (mag[dbrq_pkg::LabelW-1:0] < min_label) min_label = mag[dbrq_pkg::LabelW-1:0];
        end
      end
      pending_matches.push_back('{last: it.last,
                                  data: {1'b0, min_label, match_cnt, hit, it.idx}});
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 10)
          $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    // Accepted output: compare against the oldest expectation
    function void check_match(logic [dbrq_pkg::OutDataW-1:0] data, logic last);
      rq_result_t want;
      if (pending_matches.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: tdata %h tlast %b", data, last);
        return;
      end
      want = pending_matches.pop_front();
      check_field("neighbour_index", 64'(want.data[29:0]), 64'(data[29:0]));
      check_field("within_eps", 64'(want.data[30]), 64'(data[30]));
      check_field("match_count", 64'(want.data[47:31]), 64'(data[47:31]));
      check_field("run_label", 64'(want.data[78:48]), 64'(data[78:48]));
      check_field("tdata pad", 64'(want.data[79]), 64'(data[79]));
      check_field("tlast", 64'(want.last), 64'(last));
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [dbrq_pkg::CfgIdxW-1:0]    cfg_index_i;
  logic [dbrq_pkg::EpsW-1:0]       cfg_data_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [dbrq_pkg::InDataW-1:0]    s_axis_tdata;
  logic                            s_axis_tuser;
  logic                            s_axis_tlast;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [dbrq_pkg::OutDataW-1:0]   m_axis_tdata;
  logic                            m_axis_tlast;

  region_match_scoreboard sb;
  int                     burst_left;
  bit                     long_hold_req;

  dbscan_region_query_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Source gaps, with occasional back-to-back bursts
  function automatic int src_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 99) < 3) burst_left = $urandom_range(10, 60);
    return pick_gap();
  endfunction

  function automatic logic [3:0][dbrq_pkg::CoordW-1:0] coords(int c0, int c1, int c2,
                                                               int c3);
    return {dbrq_pkg::CoordW'(c3), dbrq_pkg::CoordW'(c2), dbrq_pkg::CoordW'(c1),
            dbrq_pkg::CoordW'(c0)};
  endfunction

  function automatic rq_item_t mk_item(dbrq_pkg::op_e op, logic [dbrq_pkg::IdxW-1:0] idx,
                                       logic [3:0][dbrq_pkg::CoordW-1:0] c,
                                       logic [dbrq_pkg::LabelInW-1:0] label, logic last);
    rq_item_t it;
    it.op    = op;
    it.idx   = idx;
    it.coord = c;
    it.label = label;
    it.last  = last;
    return it;
  endfunction

  // Coordinate within +/- 2^sc of base, clamped to the grid
  function automatic logic [dbrq_pkg::CoordW-1:0] near_coord(
      logic [dbrq_pkg::CoordW-1:0] base, int sc);
    longint v;
    v = longint'($signed(base)) + longint'($urandom_range(0, 2 << sc))
        - (longint'(1) << sc);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[dbrq_pkg::CoordW-1:0];
  endfunction

  function automatic logic [dbrq_pkg::LabelInW-1:0] rand_label();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return -$urandom_range(1, 5000);
      2:       return $urandom_range(0, 5000);
      default: return $urandom | 32'h8000_0000;
    endcase
  endfunction

  // Offer one transaction after a gap, wait for the handshake
  task automatic send_item(rq_item_t it, int gap);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tlast  <= it.last;
    s_axis_tdata  <= {2'b00, it.label, it.coord, it.idx};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_item(it);
  endtask

  // Stop offering, wait for all expected results, then wait out DrainPause
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_matches.size() != 0) @(posedge clk_i);
    repeat (DrainPause) @(posedge clk_i);
  endtask

  task automatic write_reg(dbrq_pkg::cfg_reg_e r, logic [dbrq_pkg::EpsW-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(r, v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random queries under one random register setting
  task automatic run_random_phase(int phase_no, int n_items);
    int                               sent;
    int                               n_cand;
    int                               sc;
    int                               n_dims;
    logic [dbrq_pkg::DimsW-1:0]       dims_val;
    longint unsigned                  eps_val;
    logic [3:0][dbrq_pkg::CoordW-1:0] qpt;
    logic [3:0][dbrq_pkg::CoordW-1:0] cpt;
    logic                             last_bit;
    case ($urandom_range(0, 9))
      0:       dims_val = 3'd0;
      1:       dims_val = 3'd5;
      2:       dims_val = dbrq_pkg::DimsW'($urandom_range(6, 7));
      default: dims_val = dbrq_pkg::DimsW'($urandom_range(1, 4));
    endcase
    n_dims  = (dims_val == 0) ? 1
            : ((dims_val > dbrq_pkg::MaxDims) ? dbrq_pkg::MaxDims : int'(dims_val));
    sc      = $urandom_range(0, 22);
    eps_val = ((longint'(1) << (2 * sc)) * n_dims) >> $urandom_range(0, 2);
    eps_val += $urandom_range(0, 255);
    // one phase holds the sink off while the source keeps pushing
    if (phase_no == 1) begin
      long_hold_req = 1'b1;
      burst_left    = 120;
    end
    write_reg(dbrq_pkg::CfgEps, eps_val[dbrq_pkg::EpsW-1:0]);
    write_reg(dbrq_pkg::CfgOffset, dbrq_pkg::EpsW'(dbrq_pkg::OffsW'($urandom)));
    write_reg(dbrq_pkg::CfgDims, dbrq_pkg::EpsW'(dims_val));
    sent = 0;
    while (sent < n_items) begin
      for (int d = 0; d < 4; d++) qpt[d] = dbrq_pkg::CoordW'($urandom);
      // now and then a query without its start transaction
      if ($urandom_range(0, 11) != 0) begin
        send_item(mk_item(dbrq_pkg::OpStart, dbrq_pkg::IdxW'($urandom), qpt, $urandom,
                          $urandom_range(0, 15) == 0), src_gap());
        sent++;
      end
      n_cand = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 60) : $urandom_range(1, 20);
      for (int k = 0; k < n_cand; k++) begin
        for (int d = 0; d < 4; d++)
          cpt[d] = ($urandom_range(0, 4) == 0) ? dbrq_pkg::CoordW'($urandom)
                                                : near_coord(qpt[d], sc);
        last_bit = (k == n_cand - 1) ^ ($urandom_range(0, 19) == 0);
        send_item(mk_item(dbrq_pkg::OpCandidate, dbrq_pkg::IdxW'($urandom), cpt,
                          rand_label(), last_bit), src_gap());
        sent++;
      end
      if ($urandom_range(0, 29) == 0) drain();
    end
    drain();
  endtask

  // Downstream ready: runs and stalls, or a long hold on request
  initial begin
    int run_left;
    int stall_left;
    run_left      = 0;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(0, 6);
          stall_left = pick_gap();
        end
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_match(m_axis_tdata, m_axis_tlast);
  end

  // Watchdog
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  // Main sequence
  initial begin
    sb            = new();
    burst_left    = 0;
    long_hold_req = 1'b0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = dbrq_pkg::CfgEps;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = dbrq_pkg::OpStart;
    s_axis_tlast  = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Candidates before any start, reset register values
    send_item(mk_item(dbrq_pkg::OpCandidate, 30'd3, coords(0, 0, 0, 0), 32'hFFFF_FFFB,
                      1'b0), src_gap());
    send_item(mk_item(dbrq_pkg::OpCandidate, 30'd4, coords(1, 0, 0, CMax), 32'hFFFF_FFFF,
                      1'b1), src_gap());
    drain();

    // Extremes: largest radius and offset, all four dimensions
    write_reg(dbrq_pkg::CfgEps, '1);
    write_reg(dbrq_pkg::CfgOffset, dbrq_pkg::EpsW'({dbrq_pkg::OffsW{1'b1}}));
    write_reg(dbrq_pkg::CfgDims, dbrq_pkg::EpsW'(4));
    send_item(mk_item(dbrq_pkg::OpStart, '1, coords(CMin, CMax, CMin, CMax), '0, 1'b0),
              src_gap());
    // most negative label clamps, equals running label, no change
    send_item(mk_item(dbrq_pkg::OpCandidate, '0, coords(CMax, CMin, CMax, CMin),
                      32'h8000_0000, 1'b0), src_gap());
    send_item(mk_item(dbrq_pkg::OpCandidate, '1, coords(CMax, CMin, CMax, CMin),
                      32'h7FFF_FFFF, 1'b0), src_gap());
    send_item(mk_item(dbrq_pkg::OpCandidate, 30'd1, coords(0, 0, 0, 0), 32'hFFFF_FFFF,
                      1'b1), src_gap());
    drain();

    // Radius boundary in two dimensions, miss keeps label, positive label ignored
    write_reg(dbrq_pkg::CfgEps, dbrq_pkg::EpsW'(100));
    write_reg(dbrq_pkg::CfgOffset, '0);
    write_reg(dbrq_pkg::CfgDims, dbrq_pkg::EpsW'(2));
    send_item(mk_item(dbrq_pkg::OpStart, 30'd5, coords(0, 0, CMax, CMin), '0, 1'b0),
              src_gap());
    send_item(mk_item(dbrq_pkg::OpCandidate, 30'd6, coords(6, 8, CMin, CMax), -32'sd3,
                      1'b0), src_gap());
    send_item(mk_item(dbrq_pkg::OpCandidate, 30'd7, coords(6, 9, 0, 0), -32'sd1, 1'b0),
              src_gap());
    send_item(mk_item(dbrq_pkg::OpCandidate, 30'd8, coords(-10, 0, 0, 0), 32'd9, 1'b1),
              src_gap());
    drain();

    // No dimensions in use: every candidate matches
    write_reg(dbrq_pkg::CfgDims, dbrq_pkg::EpsW'(0));
    send_item(mk_item(dbrq_pkg::OpStart, 30'd7, coords(0, 0, 0, 0), '0, 1'b0), src_gap());
    send_item(mk_item(dbrq_pkg::OpCandidate, 30'd9, coords(CMax, CMin, CMax, CMin),
                      -32'sd2, 1'b1), src_gap());
    drain();

    // Dimension count above the maximum behaves as four
    write_reg(dbrq_pkg::CfgEps, dbrq_pkg::EpsW'(3));
    write_reg(dbrq_pkg::CfgDims, dbrq_pkg::EpsW'(7));
    send_item(mk_item(dbrq_pkg::OpStart, 30'd0, coords(0, 0, 0, 0), '0, 1'b0), src_gap());
    send_item(mk_item(dbrq_pkg::OpCandidate, 30'd10, coords(0, 0, 0, 2), -32'sd1, 1'b0),
              src_gap());
    send_item(mk_item(dbrq_pkg::OpCandidate, 30'd11, coords(1, 1, 1, 0), -32'sd1, 1'b1),
              src_gap());
    drain();
    write_reg(dbrq_pkg::CfgEps, '0);
    write_reg(dbrq_pkg::CfgDims, dbrq_pkg::EpsW'(5));
    send_item(mk_item(dbrq_pkg::OpStart, 30'd2, coords(0, 0, 0, 0), '0, 1'b0), src_gap());
    send_item(mk_item(dbrq_pkg::OpCandidate, 30'd12, coords(0, 0, 0, 1), -32'sd1, 1'b1),
              src_gap());
    drain();

    // Single dimension: higher coordinates ignored
    write_reg(dbrq_pkg::CfgDims, dbrq_pkg::EpsW'(1));
    send_item(mk_item(dbrq_pkg::OpStart, 30'd3, coords(5, 0, 0, 0), '0, 1'b0), src_gap());
    send_item(mk_item(dbrq_pkg::OpCandidate, 30'd13, coords(5, CMax, CMin, CMax), -32'sd1,
                      1'b1), src_gap());
    drain();

    // Random queries across several register settings
    for (int p = 0; p < NumPhases; p++) run_random_phase(p, PhaseItems);

    if (sb.pending_matches.size() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
